FILE: design/lbbt_pkg.sv
`default_nettype none

package lbbt_pkg;

    // Table size and coordinate width.
    localparam int NUM_LABELS = 64;
    localparam int COORD_BITS = 12;

    // Derived widths.
    localparam int IDX_BITS  = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam int WALK_W    = IDX_BITS + 1;
    localparam int CNT_BITS  = $clog2(NUM_LABELS + 1);
    localparam int SIZE_W    = COORD_BITS + 1;
    localparam int LABEL_W   = 8;
    localparam int BOX_LBL_W = 7;
    localparam int EDGES_W   = 4 * COORD_BITS;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_FIELDS_W   = 2 * COORD_BITS + LABEL_W;
    localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = 1 + BOX_LBL_W + 4 * COORD_BITS;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Label numbering: object labels start at two.
    localparam logic [BOX_LBL_W-1:0] FIRST_LABEL = BOX_LBL_W'(2);
    localparam logic [BOX_LBL_W-1:0] LABEL_END   = BOX_LBL_W'(2 + NUM_LABELS);

    // Command codes carried on tuser.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Reset value of the image size registers: a full coordinate range.
    localparam logic [SIZE_W-1:0] SIZE_RESET = {1'b1, {COORD_BITS{1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    // One table entry as held in the edge memory.
    typedef struct packed {
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] left;
    } t_edges;

    // Memory read request.
    typedef struct packed {
        logic                re;
        logic [IDX_BITS-1:0] addr;
    } t_rd_req;

    // Memory write request.
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] addr;
        t_edges              data;
    } t_wr_req;

    // One result item.
    typedef struct packed {
        logic                  last;
        logic [COORD_BITS-1:0] max_y;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] min_y;
        logic [COORD_BITS-1:0] min_x;
        logic [BOX_LBL_W-1:0]  box_label;
        logic                  found;
    } t_box;

    // Largest coordinate inside an image dimension; zero counts as one.
    function automatic logic [COORD_BITS-1:0] size_limit(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] lim;
        begin
            lim = (size == '0) ? '0 : size - SIZE_W'(1);
            size_limit = (lim > {1'b0, COORD_MAX}) ? COORD_MAX : lim[COORD_BITS-1:0];
        end
    endfunction

    // Lower edge moved out by the margin, floored at zero, capped at the limit.
    function automatic logic [COORD_BITS-1:0] grow_low(input logic [COORD_BITS-1:0] v,
                                                       input logic [COORD_BITS-1:0] m,
                                                       input logic [COORD_BITS-1:0] lim);
        logic [COORD_BITS-1:0] r;
        begin
            r = (v > m) ? v - m : '0;
            grow_low = (r > lim) ? lim : r;
        end
    endfunction

    // Upper edge moved out by the margin, capped at the limit.
    function automatic logic [COORD_BITS-1:0] grow_high(input logic [COORD_BITS-1:0] v,
                                                        input logic [COORD_BITS-1:0] m,
                                                        input logic [COORD_BITS-1:0] lim);
        logic [COORD_BITS:0] r;
        begin
            r = {1'b0, v} + {1'b0, m};
            grow_high = (r > {1'b0, lim}) ? lim : r[COORD_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/lbbt_ram.sv
`default_nettype none

module lbbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port that holds when not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/lbbt_pixel.sv
`default_nettype none

module lbbt_pixel (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_pix_valid,
    input  wire logic [lbbt_pkg::COORD_BITS-1:0]     i_pix_x,
    input  wire logic [lbbt_pkg::COORD_BITS-1:0]     i_pix_y,
    input  wire logic [lbbt_pkg::LABEL_W-1:0]        i_label,
    input  wire logic                                i_clear,
    input  wire lbbt_pkg::t_edges                    i_rdata,
    output lbbt_pkg::t_rd_req                        o_rd,
    output lbbt_pkg::t_wr_req                        o_wr,
    output logic      [lbbt_pkg::NUM_LABELS-1:0]     o_seen,
    output logic      [lbbt_pkg::CNT_BITS-1:0]       o_count
);

    logic [lbbt_pkg::BOX_LBL_W-1:0]  lab_u;
    logic [lbbt_pkg::BOX_LBL_W-1:0]  lab_off;
    logic                            lab_ok;

    logic                            r_s1_valid;
    logic [lbbt_pkg::IDX_BITS-1:0]   r_s1_idx;
    logic [lbbt_pkg::COORD_BITS-1:0] r_s1_x;
    logic [lbbt_pkg::COORD_BITS-1:0] r_s1_y;

    logic                            r_fw_valid;
    logic [lbbt_pkg::IDX_BITS-1:0]   r_fw_idx;
    lbbt_pkg::t_edges                r_fw_data;

    logic [lbbt_pkg::NUM_LABELS-1:0] r_seen;
    logic [lbbt_pkg::CNT_BITS-1:0]   r_count;

    lbbt_pkg::t_edges                base;
    lbbt_pkg::t_edges                merged;
    logic                            hit;

    // Only non-negative labels inside the table's range are tracked.
    assign lab_u   = i_label[lbbt_pkg::BOX_LBL_W-1:0];
    assign lab_off = lab_u - lbbt_pkg::FIRST_LABEL;
    assign lab_ok  = !i_label[lbbt_pkg::LABEL_W-1] && (lab_u >= lbbt_pkg::FIRST_LABEL)
                     && (lab_u < lbbt_pkg::LABEL_END);

    // The entry is read as the request is taken; the merge follows in the next cycle.
    assign o_rd.re   = i_pix_valid && lab_ok;
    assign o_rd.addr = lab_off[lbbt_pkg::IDX_BITS-1:0];

    // The previous write lands on the same edge as this entry's read, so take it
    // from the forwarding register when the indexes match.
    assign base = (r_fw_valid && (r_fw_idx == r_s1_idx)) ? r_fw_data : i_rdata;
    assign hit  = r_seen[r_s1_idx];

    // The first pixel of a label starts its box; later ones widen it.
    always_comb begin
        if (hit) begin
            merged.left   = (r_s1_x < base.left)   ? r_s1_x : base.left;
            merged.right  = (r_s1_x > base.right)  ? r_s1_x : base.right;
            merged.top    = (r_s1_y < base.top)    ? r_s1_y : base.top;
            merged.bottom = (r_s1_y > base.bottom) ? r_s1_y : base.bottom;
        end else begin
            merged.left   = r_s1_x;
            merged.right  = r_s1_x;
            merged.top    = r_s1_y;
            merged.bottom = r_s1_y;
        end
    end

    assign o_wr.we   = r_s1_valid;
    assign o_wr.addr = r_s1_idx;
    assign o_wr.data = merged;

    // Merge stage and forwarding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_rd.re;
            r_fw_valid <= r_s1_valid;
        end
        r_s1_idx  <= o_rd.addr;
        r_s1_x    <= i_pix_x;
        r_s1_y    <= i_pix_y;
        r_fw_idx  <= r_s1_idx;
        r_fw_data <= merged;
    end

    // Seen bits and the count of seen labels; a flush clears both at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_seen  <= '0;
            r_count <= '0;
        end else if (r_s1_valid && !hit) begin
            r_seen[r_s1_idx] <= 1'b1;
            r_count          <= r_count + lbbt_pkg::CNT_BITS'(1);
        end
    end

    assign o_seen  = r_seen;
    assign o_count = r_count;

endmodule

`default_nettype wire

FILE: design/lbbt_flush.sv
`default_nettype none

module lbbt_flush (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_flush,
    input  wire logic [lbbt_pkg::NUM_LABELS-1:0]     i_seen,
    input  wire logic [lbbt_pkg::CNT_BITS-1:0]       i_count,
    input  wire lbbt_pkg::t_edges                    i_rdata,
    input  wire logic [lbbt_pkg::COORD_BITS-1:0]     i_margin,
    input  wire logic [lbbt_pkg::COORD_BITS-1:0]     i_xlim,
    input  wire logic [lbbt_pkg::COORD_BITS-1:0]     i_ylim,
    input  wire logic                                i_out_ready,
    output logic                                     o_idle,
    output logic                                     o_clear,
    output lbbt_pkg::t_rd_req                        o_rd,
    output logic                                     o_out_valid,
    output lbbt_pkg::t_box                           o_box
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_EMPTY
    } t_state;

    localparam logic [lbbt_pkg::WALK_W-1:0] WALK_END = lbbt_pkg::WALK_W'(lbbt_pkg::NUM_LABELS);

    t_state                          r_state;
    logic [lbbt_pkg::WALK_W-1:0]     r_idx;
    logic [lbbt_pkg::CNT_BITS-1:0]   r_left;
    logic                            r_b_valid;
    logic [lbbt_pkg::IDX_BITS-1:0]   r_b_idx;
    logic                            r_b_last;
    logic                            r_out_valid;
    lbbt_pkg::t_box                  r_out;

    logic                            out_free;
    logic                            b_move;
    logic                            walk_done;
    logic                            a_adv;
    logic                            a_hit;
    lbbt_pkg::t_box                  box;
    lbbt_pkg::t_box                  empty_box;

    // Handshake between the read stage, the box stage and the output register.
    assign out_free  = !r_out_valid || i_out_ready;
    assign b_move    = r_b_valid && out_free;
    assign walk_done = (r_idx == WALK_END);
    assign a_adv     = (r_state == S_WALK) && !walk_done && (!r_b_valid || out_free);
    assign a_hit     = a_adv && i_seen[r_idx[lbbt_pkg::IDX_BITS-1:0]];

    assign o_rd.re   = a_hit;
    assign o_rd.addr = r_idx[lbbt_pkg::IDX_BITS-1:0];

    // The walk ends once it has passed every entry and the last box has moved on.
    assign o_clear = (r_state == S_WALK) && walk_done && !r_b_valid;
    assign o_idle  = (r_state == S_IDLE);

    // Grow and clamp the box read from the edge memory.
    always_comb begin
        box.found     = 1'b1;
        box.box_label = {{(lbbt_pkg::BOX_LBL_W - lbbt_pkg::IDX_BITS){1'b0}}, r_b_idx}
                        + lbbt_pkg::FIRST_LABEL;
        box.min_x     = lbbt_pkg::grow_low(i_rdata.left, i_margin, i_xlim);
        box.min_y     = lbbt_pkg::grow_low(i_rdata.top, i_margin, i_ylim);
        box.max_x     = lbbt_pkg::grow_high(i_rdata.right, i_margin, i_xlim);
        box.max_y     = lbbt_pkg::grow_high(i_rdata.bottom, i_margin, i_ylim);
        box.last      = r_b_last;
    end

    // The single result of a flush that found nothing.
    always_comb begin
        empty_box      = '0;
        empty_box.last = 1'b1;
    end

    // State, walk counters and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_left      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_flush) begin
                        r_state <= S_START;
                    end
                end
                // The start state lets the last pixel's update reach the count.
                S_START: begin
                    r_idx  <= '0;
                    r_left <= i_count;
                    if (i_count == '0) begin
                        r_state <= S_EMPTY;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (o_clear) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (a_adv) begin
                r_idx <= r_idx + lbbt_pkg::WALK_W'(1);
            end
            if (a_hit) begin
                r_b_valid <= 1'b1;
                r_left    <= r_left - lbbt_pkg::CNT_BITS'(1);
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end

            if (b_move || ((r_state == S_EMPTY) && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (a_hit) begin
            r_b_idx  <= r_idx[lbbt_pkg::IDX_BITS-1:0];
            r_b_last <= (r_left == lbbt_pkg::CNT_BITS'(1));
        end
        if (b_move) begin
            r_out <= box;
        end else if ((r_state == S_EMPTY) && out_free) begin
            r_out <= empty_box;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_box       = r_out;

endmodule

`default_nettype wire

FILE: design/label_bounding_box_tracker_top.sv
`default_nettype none

// Per-label bounding box tracker. Pixel requests (tuser 0) carry a column, a row
// and a signed label; labels 2 to 65 widen that label's box, anything else is
// dropped. Pixels are taken one per cycle while no flush runs: the box edges
// live in a 64-entry memory that is read as the request is taken and written
// back in the next cycle, with the previous write forwarded when two pixels of
// one label follow each other. A flush request (tuser 1) emits the box of every
// seen label in ascending label order, grown by the margin and clamped to the
// image, with tlast on the final box; a flush that saw nothing emits one empty
// result with found 0 and tlast set. A flush of a non-empty table holds tready
// low through a start state, a walk over every table entry one per cycle, a
// wait for the final box to move on, and a clearing step. An empty flush holds
// it through the start state and the empty-result state. Output stalls lengthen
// both, and no request is taken meanwhile. The seen bits are flip-flops cleared
// at reset and at the end of each non-empty flush, so the edge memory needs no
// clearing pass. Configuration: index 0 margin, 1 image width, 2 image height,
// written by the user only while the block is idle; the block does not check it.
module label_bounding_box_tracker_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Pixel and flush requests.
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // tdata from bit 0: pix_x, pix_y, label.
    input  wire logic [lbbt_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // tuser: cmd.
    input  wire logic                                  i_s_axis_tuser,
    // Box results.
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // tdata from bit 0: found, box_label, box_min_x, box_min_y, box_max_x, box_max_y.
    output logic      [lbbt_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                       o_m_axis_tlast,
    // Configuration writes.
    input  wire logic                                  i_cfg_we,
    input  wire logic [lbbt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [lbbt_pkg::SIZE_W-1:0]           i_cfg_wdata
);

    localparam int CB = lbbt_pkg::COORD_BITS;

    logic [CB-1:0]                   r_margin;
    logic [lbbt_pkg::SIZE_W-1:0]     r_width;
    logic [lbbt_pkg::SIZE_W-1:0]     r_height;
    logic [CB-1:0]                   xlim;
    logic [CB-1:0]                   ylim;

    logic                            in_acc;
    logic                            pix_valid;
    logic                            flush_req;
    logic                            idle;
    logic                            clear;
    lbbt_pkg::t_rd_req               pix_rd;
    lbbt_pkg::t_rd_req               fl_rd;
    lbbt_pkg::t_wr_req               pix_wr;
    lbbt_pkg::t_edges                rdata;
    logic [lbbt_pkg::EDGES_W-1:0]    rdata_raw;
    logic [lbbt_pkg::NUM_LABELS-1:0] seen;
    logic [lbbt_pkg::CNT_BITS-1:0]   count;
    lbbt_pkg::t_box                  box;
    logic                            ram_re;
    logic [lbbt_pkg::IDX_BITS-1:0]   ram_raddr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
            r_width  <= lbbt_pkg::SIZE_RESET;
            r_height <= lbbt_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lbbt_pkg::REG_MARGIN:       r_margin <= i_cfg_wdata[CB-1:0];
                lbbt_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                lbbt_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign xlim = lbbt_pkg::size_limit(r_width);
    assign ylim = lbbt_pkg::size_limit(r_height);

    // Request decode.
    assign o_s_axis_tready = idle;
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign pix_valid = in_acc && (i_s_axis_tuser == lbbt_pkg::CMD_PIXEL);
    assign flush_req = in_acc && (i_s_axis_tuser == lbbt_pkg::CMD_FLUSH);

    lbbt_pixel u_pixel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (pix_valid),
        .i_pix_x     (i_s_axis_tdata[CB-1:0]),
        .i_pix_y     (i_s_axis_tdata[2*CB-1:CB]),
        .i_label     (i_s_axis_tdata[2*CB+lbbt_pkg::LABEL_W-1:2*CB]),
        .i_clear     (clear),
        .i_rdata     (rdata),
        .o_rd        (pix_rd),
        .o_wr        (pix_wr),
        .o_seen      (seen),
        .o_count     (count)
    );

    lbbt_flush u_flush (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flush     (flush_req),
        .i_seen      (seen),
        .i_count     (count),
        .i_rdata     (rdata),
        .i_margin    (r_margin),
        .i_xlim      (xlim),
        .i_ylim      (ylim),
        .i_out_ready (i_m_axis_tready),
        .o_idle      (idle),
        .o_clear     (clear),
        .o_rd        (fl_rd),
        .o_out_valid (o_m_axis_tvalid),
        .o_box       (box)
    );

    // The pixel path and the flush walk never read in the same cycle.
    assign ram_re    = pix_rd.re || fl_rd.re;
    assign ram_raddr = fl_rd.re ? fl_rd.addr : pix_rd.addr;

    lbbt_ram #(
        .WIDTH (lbbt_pkg::EDGES_W),
        .DEPTH (lbbt_pkg::NUM_LABELS)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (pix_wr.we),
        .i_waddr (pix_wr.addr),
        .i_wdata (pix_wr.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata_raw)
    );

    assign rdata = rdata_raw;

    // Result packing, zero-filled up to whole bytes.
    assign o_m_axis_tdata = lbbt_pkg::OUT_DATA_W'({box.max_y, box.max_x, box.min_y, box.min_x,
                                                   box.box_label, box.found});
    assign o_m_axis_tlast = box.last;

    // The two read sources must never collide on the memory's read port.
    a_single_reader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pix_rd.re && fl_rd.re))
        else $error("edge memory read by pixel path and flush walk at once");

    // The table is only cleared when no pixel update is writing back.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |-> !pix_wr.we)
        else $error("table cleared while a pixel update was in flight");

    // The seen count never exceeds the number of table entries.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= lbbt_pkg::CNT_BITS'(lbbt_pkg::NUM_LABELS))
        else $error("seen count beyond table size");

    // After a clear the next cycle starts with an empty table.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> (count == '0) && (seen == '0))
        else $error("table not empty after clear");

endmodule

`default_nettype wire
